// ===== rtl/asm_pkg.sv =====
package asm_pkg;

    // pattern and alphabet sizes
    localparam int MAX_PATTERN   = 32;
    localparam int SYMBOL_BITS   = 8;
    localparam int POSITION_BITS = 32;

    localparam int ALPHA_SIZE = 1 << SYMBOL_BITS;
    // bits for a state 0..MAX_PATTERN
    localparam int Q_BITS     = $clog2(MAX_PATTERN + 1);
    // bits for a pattern store index 0..MAX_PATTERN-1
    localparam int PAT_AW     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    // transition table: one row of ALPHA_SIZE entries per state
    localparam int TABLE_SIZE = (MAX_PATTERN + 1) * ALPHA_SIZE;
    localparam int TBL_AW     = Q_BITS + SYMBOL_BITS;

    // result queue depth: covers one read in flight plus two queued beats
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_AW    = 2;

    // command codes
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    typedef struct packed {
        logic [Q_BITS-1:0]        state;
        logic                     found;
        logic [POSITION_BITS-1:0] start;
        logic [POSITION_BITS-1:0] pos;
    } t_result;

endpackage

// ===== rtl/automaton_string_matcher_unit.sv =====
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_cmd, i_symbol, i_last_pattern
// result    out        o_valid / i_stall  o_match_state, o_match_found,
//                                         o_match_start, o_text_position
//
// text bytes: one per cycle while o_stall is low; the next read address uses the table read data.
// results are registered from the table read and queue in a three-beat fifo.
// final pattern byte: table build of m + 1 rows of ALPHA_SIZE entries for
// pattern length m, one table entry written per cycle in each row sweep; o_stall is high.
// reset (synchronous, i_rst_n low) clears control state only, no memory pass.
// pattern bytes wait while a text read is in flight.
module automaton_string_matcher_unit
    import asm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_symbol,
    input  logic        i_last_pattern,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_match_state,
    output logic        o_match_found,
    output logic [31:0] o_match_start,
    output logic [31:0] o_text_position
);

    // sequencer codes
    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_PAT   = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    // control registers
    logic [1:0]               r_state;
    logic                     r_loading;
    logic                     r_built;
    logic [Q_BITS-1:0]        r_len;
    logic [Q_BITS-1:0]        r_cur;
    logic [POSITION_BITS-1:0] r_pos;

    // build sequencer
    logic [Q_BITS-1:0]      r_q;
    logic [Q_BITS-1:0]      r_fail;
    logic [Q_BITS-1:0]      r_fnext;
    logic [SYMBOL_BITS-1:0] r_a;
    logic                   r_wv;
    logic [SYMBOL_BITS-1:0] r_wa;

    // text read in flight
    logic                     r_p1_v;
    logic [POSITION_BITS-1:0] r_p1_pos;

    // result fifo
    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp;
    logic [FIFO_AW-1:0]   r_rp;
    logic [FIFO_AW-1:0]   r_cnt;

    // memories
    logic [SYMBOL_BITS-1:0] r_pat_mem [MAX_PATTERN];
    logic [SYMBOL_BITS-1:0] r_pat_rd;
    logic [Q_BITS-1:0]      r_tbl_mem [TABLE_SIZE];
    logic [Q_BITS-1:0]      r_tbl_rd;

    logic [SYMBOL_BITS-1:0] sym;
    logic                   accept;
    logic                   text_ok;
    logic                   pat_ok;
    logic                   text_step;
    logic                   pat_step;
    logic [Q_BITS-1:0]      eff_len;
    logic                   pat_room;
    logic [Q_BITS-1:0]      p1_state;
    logic [Q_BITS-1:0]      cur_now;
    logic [TBL_AW-1:0]      tbl_raddr;
    logic                   tbl_we;
    logic [TBL_AW-1:0]      tbl_waddr;
    logic [Q_BITS-1:0]      tbl_wdata;
    logic                   hit;
    logic                   capture;
    logic                   push;
    logic                   pop;
    t_result                p1_res;
    t_result                head;

    assign sym = i_symbol[SYMBOL_BITS-1:0];

    // input flow control
    assign text_ok = r_loading
                     || ({1'b0, r_cnt} + {{FIFO_AW{1'b0}}, r_p1_v} < (FIFO_AW+1)'(FIFO_DEPTH));
    assign pat_ok  = !r_p1_v;
    always_comb begin
        if (r_state != ST_RUN) begin
            o_stall = 1'b1;
        end else if (i_cmd == CMD_TEXT) begin
            o_stall = !text_ok;
        end else begin
            o_stall = !pat_ok;
        end
    end
    assign accept    = i_valid && !o_stall;
    assign text_step = accept && (i_cmd == CMD_TEXT) && !r_loading;
    assign pat_step  = accept && (i_cmd == CMD_PATTERN);

    // pattern append bookkeeping
    assign eff_len  = r_loading ? r_len : '0;
    assign pat_room = eff_len < Q_BITS'(MAX_PATTERN);

    // state returned by the in-flight text read
    assign p1_state = r_built ? r_tbl_rd : '0;
    assign cur_now  = r_p1_v ? p1_state : r_cur;

    // table read address: build sweep or text step
    assign tbl_raddr = (r_state == ST_RUN) ? {cur_now, sym} : {r_fail, r_a};

    // build write stage
    assign hit       = (r_q < r_len) && (r_wa == r_pat_rd);
    assign capture   = r_wv && hit && (r_q != '0);
    assign tbl_we    = r_wv;
    assign tbl_waddr = {r_q, r_wa};
    always_comb begin
        priority if (hit) begin
            tbl_wdata = r_q + Q_BITS'(1);
        end else if (r_q == '0) begin
            tbl_wdata = '0;
        end else begin
            tbl_wdata = r_tbl_rd;
        end
    end

    // transition table memory
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        r_tbl_rd <= r_tbl_mem[tbl_raddr];
    end

    // pattern store memory
    always_ff @(posedge i_clk) begin
        if (pat_step && pat_room) begin
            r_pat_mem[eff_len[PAT_AW-1:0]] <= sym;
        end
        r_pat_rd <= r_pat_mem[r_q[PAT_AW-1:0]];
    end

    // sequencer and match state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_loading <= 1'b0;
            r_built   <= 1'b0;
            r_len     <= '0;
            r_cur     <= '0;
            r_pos     <= '0;
            r_q       <= '0;
            r_fail    <= '0;
            r_fnext   <= '0;
            r_a       <= '0;
            r_wv      <= 1'b0;
            r_p1_v    <= 1'b0;
        end else begin
            r_wv   <= (r_state == ST_SWEEP);
            r_p1_v <= text_step;
            if (capture) begin
                r_fnext <= r_tbl_rd;
            end
            if (r_p1_v) begin
                r_cur <= p1_state;
            end
            unique case (r_state)
                ST_RUN: begin
                    if (text_step) begin
                        r_p1_pos <= r_pos;
                        r_pos    <= r_pos + POSITION_BITS'(1);
                    end
                    if (pat_step) begin
                        r_len     <= pat_room ? eff_len + Q_BITS'(1) : eff_len;
                        r_loading <= !i_last_pattern;
                        if (i_last_pattern) begin
                            r_state <= ST_PAT;
                            r_q     <= '0;
                            r_fnext <= '0;
                        end
                    end
                end
                ST_PAT: begin
                    r_fail  <= r_fnext;
                    r_a     <= '0;
                    r_state <= ST_SWEEP;
                end
                ST_SWEEP: begin
                    r_wa <= r_a;
                    r_a  <= r_a + SYMBOL_BITS'(1);
                    if (r_a == {SYMBOL_BITS{1'b1}}) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_q == r_len) begin
                        r_state <= ST_RUN;
                        r_cur   <= '0;
                        r_pos   <= '0;
                        r_built <= 1'b1;
                    end else begin
                        r_q     <= r_q + Q_BITS'(1);
                        r_state <= ST_PAT;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    // result of the text read in flight
    always_comb begin
        p1_res.state = p1_state;
        p1_res.found = (p1_state == r_len);
        p1_res.pos   = r_p1_pos;
        p1_res.start = p1_res.found
                       ? r_p1_pos - POSITION_BITS'(r_len) + POSITION_BITS'(1) : '0;
    end

    // result fifo
    assign push = r_p1_v;
    assign pop  = o_valid && !i_stall;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wp + FIFO_AW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rp + FIFO_AW'(1);
            end
            r_cnt <= r_cnt + FIFO_AW'(push) - FIFO_AW'(pop);
        end
    end
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= p1_res;
        end
    end

    // output beat
    assign head            = r_fifo[r_rp];
    assign o_valid         = r_cnt != '0;
    assign o_match_state   = 6'(head.state);
    assign o_match_found   = head.found;
    assign o_match_start   = 32'(head.start);
    assign o_text_position = 32'(head.pos);

    // table writes only come from the build sweep
    a_write_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv |-> (r_state == ST_SWEEP || r_state == ST_DRAIN))
        else $error("table write outside build");

    // failure state stays below the row being built
    a_fail_below_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP && r_q != '0) |-> (r_fail < r_q))
        else $error("failure state not below current state");

    // fifo never overflows with the read in flight
    a_fifo_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cnt} + {{FIFO_AW{1'b0}}, r_p1_v}) <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result fifo overflow");

    // a text read is never in flight during a table sweep or drain
    a_no_text_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_v |-> (r_state == ST_RUN || r_state == ST_PAT))
        else $error("text read overlaps build");

    // the build starts from a clear state machine
    a_build_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pat_step && i_last_pattern) |=> (r_state == ST_PAT && r_q == '0 && !r_loading))
        else $error("build did not start");

endmodule
